[rtl/core/wfba_pkg.sv]
// worst-fit block allocator: shared types, codes and default sizes
// used by the controller, datapath and top level; no dependencies
package wfba_pkg;

  // default sizing of the partition table
  localparam int MAX_PARTITIONS_DEF  = 128;
  localparam int SIZE_BITS_DEF       = 16;
  localparam int REQUEST_ID_BITS_DEF = 8;

  // fixed port field widths
  localparam int IN_SIZE_W  = 16;
  localparam int STATUS_W   = 2;
  localparam int OUT_IDX_W  = 7;
  localparam int OUT_REQ_W  = 8;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic acc_load;   // load item accepted this cycle
    logic acc_alloc;  // allocate item accepted this cycle
    logic scan_rd;    // read next table entry
    logic finish;     // close the scan, mark the winner
    logic emit;       // move pending result into output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;      // no partition loaded
    logic last;       // scan pointer is at the last loaded entry
    logic out_free;   // output register can take a result
  } stat_t;

endpackage

[rtl/core/wfba_ram.sv]
// wfba_ram: generic single write port, single read port ram
// registered read data, no reset; no dependencies
module wfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/wfba_ctrl.sv]
// wfba_ctrl: sequencer for load, scan, finish and result transfer
// depends on wfba_pkg for the command and status structs
module wfba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_opcode,
  output logic             in_ready,
  input  wfba_pkg::stat_t  st,
  output wfba_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == wfba_pkg::OP_ALLOC) begin
            cmd.acc_alloc = 1'b1;
            state_nxt     = st.empty ? S_EMIT : S_SCAN;
          end else begin
            cmd.acc_load = 1'b1;
            state_nxt    = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last entry is compared in this cycle
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a scan never starts on an empty table
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !st.empty)
    else $error("scan running on an empty table");

  // one item in flight: no input taken right after a transfer in
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

endmodule

[rtl/core/wfba_datapath.sv]
// wfba_datapath: partition table, counters, worst-fit compare and result registers
// depends on wfba_pkg and wfba_ram
module wfba_datapath #(
  parameter int MAX_PARTITIONS  = wfba_pkg::MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS       = wfba_pkg::SIZE_BITS_DEF,
  parameter int REQUEST_ID_BITS = wfba_pkg::REQUEST_ID_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wfba_pkg::cmd_t                     cmd,
  output wfba_pkg::stat_t                    st,
  input  logic [wfba_pkg::IN_SIZE_W-1:0]     in_size_value,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [wfba_pkg::STATUS_W-1:0]      out_status,
  output logic [wfba_pkg::OUT_IDX_W-1:0]     out_block_index,
  output logic [wfba_pkg::OUT_REQ_W-1:0]     out_request_index
);

  localparam int IDX_W  = $clog2(MAX_PARTITIONS);
  localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
  localparam int REQ_W  = REQUEST_ID_BITS;
  localparam int WORD_W = REQ_W + 1 + SIZE_BITS;
  localparam int OIW    = wfba_pkg::OUT_IDX_W;
  localparam int ORW    = wfba_pkg::OUT_REQ_W;
  localparam int ISW    = wfba_pkg::IN_SIZE_W;

  // input size cut or widened to the table width
  logic [SIZE_BITS+ISW-1:0] size_ext;
  logic [SIZE_BITS-1:0]     in_size;

  logic [CNT_W-1:0]     loaded_cnt_r;
  logic [CNT_W-1:0]     last_cnt;
  logic                 full;
  logic [IDX_W-1:0]     load_idx;
  logic [REQ_W-1:0]     req_cnt_r;
  logic [REQ_W-1:0]     req_r;
  logic [SIZE_BITS-1:0] need_r;
  logic [IDX_W-1:0]     scan_idx_r;
  logic                 cmp_valid_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 found_r;
  logic [SIZE_BITS-1:0] best_size_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic                 hit;

  wfba_pkg::status_t    res_status_r;
  logic [IDX_W-1:0]     res_idx_r;
  logic [REQ_W-1:0]     res_req_r;

  logic                 out_valid_r;
  logic [wfba_pkg::STATUS_W-1:0] out_status_r;
  logic [OIW-1:0]       out_idx_r;
  logic [ORW-1:0]       out_req_r;
  logic [IDX_W+OIW-1:0] idx_ext;
  logic [REQ_W+ORW-1:0] req_ext;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;
  logic [SIZE_BITS-1:0] entry_size;
  logic                 entry_used;

  assign size_ext = {{SIZE_BITS{1'b0}}, in_size_value};
  assign in_size  = size_ext[SIZE_BITS-1:0];

  assign full     = loaded_cnt_r == CNT_W'(MAX_PARTITIONS);
  assign load_idx = loaded_cnt_r[IDX_W-1:0];
  assign last_cnt = loaded_cnt_r - CNT_W'(1);

  // status to the controller
  assign st.empty    = loaded_cnt_r == '0;
  assign st.last     = scan_idx_r == last_cnt[IDX_W-1:0];
  assign st.out_free = !out_valid_r || out_ready;

  // table word: {owner, used, size}
  assign entry_size = ram_rdata[SIZE_BITS-1:0];
  assign entry_used = ram_rdata[SIZE_BITS];

  // table write: append on load, mark winner on finish
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_idx;
    ram_wdata = {{REQ_W{1'b0}}, 1'b0, in_size};
    if (cmd.acc_load && !full) begin
      ram_we = 1'b1;
    end else if (cmd.finish && found_r) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_r;
      ram_wdata = {req_r, 1'b1, best_size_r};
    end
  end

  wfba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_PARTITIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.scan_rd),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  // worst-fit compare; strict greater keeps the lowest index on ties
  assign hit = cmp_valid_r && !entry_used && (entry_size >= need_r)
               && (!found_r || (entry_size > best_size_r));

  // counters and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_cnt_r <= '0;
      req_cnt_r    <= '0;
      cmp_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      scan_idx_r   <= '0;
    end else begin
      cmp_valid_r <= cmd.scan_rd;
      if (cmd.acc_load && !full) begin
        loaded_cnt_r <= loaded_cnt_r + CNT_W'(1);
      end
      if (cmd.acc_alloc) begin
        req_cnt_r  <= req_cnt_r + REQ_W'(1);
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // request payload and best candidate
  always_ff @(posedge clk) begin
    if (cmd.acc_alloc) begin
      req_r  <= req_cnt_r;
      need_r <= in_size;
    end
    if (cmd.scan_rd) begin
      cmp_idx_r <= scan_idx_r;
    end
    if (hit) begin
      best_size_r <= entry_size;
      best_idx_r  <= cmp_idx_r;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      res_status_r <= full ? wfba_pkg::ST_FULL : wfba_pkg::ST_LOADED;
      res_idx_r    <= full ? '0 : load_idx;
      res_req_r    <= '0;
    end else if (cmd.acc_alloc) begin
      res_status_r <= wfba_pkg::ST_NO_FIT;
      res_idx_r    <= '0;
      res_req_r    <= req_cnt_r;
    end else if (cmd.finish && found_r) begin
      res_status_r <= wfba_pkg::ST_ALLOCATED;
      res_idx_r    <= best_idx_r;
    end
  end

  assign idx_ext = {{OIW{1'b0}}, res_idx_r};
  assign req_ext = {{ORW{1'b0}}, res_req_r};

  // output register, decoupled from the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_idx_r    <= idx_ext[OIW-1:0];
      out_req_r    <= req_ext[ORW-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_index   = out_idx_r;
  assign out_request_index = out_req_r;

  // fill count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_cnt_r <= CNT_W'(MAX_PARTITIONS))
    else $error("loaded count beyond table depth");

  // a chosen partition always covers the request
  a_winner_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && found_r |-> best_size_r >= need_r)
    else $error("winner smaller than request");

  // request number advances by one per allocate transfer
  a_req_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_alloc |=> req_cnt_r == $past(req_cnt_r) + REQ_W'(1))
    else $error("request counter step wrong");

  // result is never dropped while the output waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r || out_ready)
    else $error("pending output overwritten");

endmodule

[rtl/core/worst_fit_block_allocator_top.sv]
// worst_fit_block_allocator_top: worst-fit partition allocator top level
// depends on wfba_pkg, wfba_ctrl, wfba_datapath (which holds wfba_ram)
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   in       | in_valid, in_ready, in_opcode,           | sink
//            | in_size_value                            |
//   out      | out_valid, out_ready, out_status,        | source
//            | out_block_index, out_request_index       |
//
// a load goes from transfer in straight to the emit state; an allocate runs
// the scan, then the drain and finish states (an empty table goes straight to
// emit); the scan reads one table entry per cycle from the single-read-port
// partition ram; a result still held in the output register adds its wait.
// one item is in work at a time; the result sits in an output register, so
// a new item is taken while the previous result waits for out_ready.
// reset clears the counters and control only; the table needs no clearing
// pass, since only loaded entries are ever read.
module worst_fit_block_allocator_top #(
  parameter int MAX_PARTITIONS  = wfba_pkg::MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS       = wfba_pkg::SIZE_BITS_DEF,
  parameter int REQUEST_ID_BITS = wfba_pkg::REQUEST_ID_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic [wfba_pkg::IN_SIZE_W-1:0]     in_size_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wfba_pkg::STATUS_W-1:0]      out_status,
  output logic [wfba_pkg::OUT_IDX_W-1:0]     out_block_index,
  output logic [wfba_pkg::OUT_REQ_W-1:0]     out_request_index
);

  wfba_pkg::cmd_t  cmd;
  wfba_pkg::stat_t st;

  // sequencer
  wfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // table, counters and result path
  wfba_datapath #(
    .MAX_PARTITIONS  (MAX_PARTITIONS),
    .SIZE_BITS       (SIZE_BITS),
    .REQUEST_ID_BITS (REQUEST_ID_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_size_value     (in_size_value),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_block_index   (out_block_index),
    .out_request_index (out_request_index)
  );

endmodule

[sim/tb_worst_fit_block_allocator_top.sv]
// testbench for worst_fit_block_allocator_top: directed and random load/allocate traffic
// checked against an in-bench worst-fit table predictor; depends on wfba_pkg and the rtl
`timescale 1ns / 1ps

module tb_worst_fit_block_allocator_top;

  localparam int MAX_PART     = wfba_pkg::MAX_PARTITIONS_DEF;
  localparam int DRAIN_CYCLES = MAX_PART + 16;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int SZW          = wfba_pkg::IN_SIZE_W;
  localparam int BLKW         = wfba_pkg::OUT_IDX_W;
  localparam int REQW         = wfba_pkg::OUT_REQ_W;

  typedef struct packed {
    wfba_pkg::status_t      status;
    logic [BLKW-1:0]        blk;
    logic [REQW-1:0]        req;
  } grant_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_opcode = wfba_pkg::OP_LOAD;
  logic [SZW-1:0]         in_size_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [wfba_pkg::STATUS_W-1:0] out_status;
  logic [BLKW-1:0]        out_block_index;
  logic [REQW-1:0]        out_request_index;

  // predictor copy of the partition table
  logic [SZW-1:0]         part_size [MAX_PART];
  bit                     part_used [MAX_PART];
  int                     loaded_cnt = 0;
  logic [REQW-1:0]        req_ctr = '0;

  grant_t                 grant_queue [$];
  logic [SZW-1:0]         sent_sizes [$];
  bit                     allow_idle = 1'b1;
  int                     stall_left = 0;
  int                     cycle_cnt = 0;
  int                     err_cnt = 0;
  int                     n_loaded = 0;
  int                     n_granted = 0;
  int                     n_no_fit = 0;
  int                     n_full = 0;
  int                     n_alloc = 0;

  worst_fit_block_allocator_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_size_value     (in_size_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_block_index   (out_block_index),
    .out_request_index (out_request_index)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // worst-fit table update for one accepted item
  function automatic grant_t worst_fit_step(wfba_pkg::opcode_t op,
                                            logic [SZW-1:0] sz);
    grant_t g;
    bit found;
    int best;
    logic [SZW-1:0] best_sz;
    g.status = wfba_pkg::ST_NO_FIT;
    g.blk = '0;
    g.req = '0;
    found = 1'b0;
    best = 0;
    best_sz = '0;
    if (op == wfba_pkg::OP_LOAD) begin
      if (loaded_cnt >= MAX_PART) begin
        g.status = wfba_pkg::ST_FULL;
      end else begin
        part_size[loaded_cnt] = sz;
        part_used[loaded_cnt] = 1'b0;
        g.status = wfba_pkg::ST_LOADED;
        g.blk = BLKW'(loaded_cnt);
        loaded_cnt++;
      end
    end else begin
      g.req = req_ctr;
      req_ctr = req_ctr + 1'b1;
      // largest free partition that fits, lowest index on ties
      for (int j = 0; j < loaded_cnt; j++) begin
        if (!part_used[j] && part_size[j] >= sz && (!found || part_size[j] > best_sz)) begin
          found = 1'b1;
          best = j;
          best_sz = part_size[j];
        end
      end
      if (found) begin
        part_used[best] = 1'b1;
        g.status = wfba_pkg::ST_ALLOCATED;
        g.blk = BLKW'(best);
      end
    end
    return g;
  endfunction

  // predict on every input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      grant_queue.push_back(worst_fit_step(wfba_pkg::opcode_t'(in_opcode), in_size_value));
    end
  end

  // compare every output transfer with the oldest prediction
  always @(posedge clk) begin
    grant_t exp_g;
    if (rst_n && out_valid && out_ready) begin
      if (grant_queue.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result status %0d block %0d request %0d", $time,
                 out_status, out_block_index, out_request_index);
      end else begin
        exp_g = grant_queue.pop_front();
        if (out_status !== exp_g.status) begin
          err_cnt++;
          $display("%0t: status expected %0d actual %0d", $time, exp_g.status, out_status);
        end
        if (out_block_index !== exp_g.blk) begin
          err_cnt++;
          $display("%0t: block_index expected %0d actual %0d", $time, exp_g.blk,
                   out_block_index);
        end
        if (out_request_index !== exp_g.req) begin
          err_cnt++;
          $display("%0t: request_index expected %0d actual %0d", $time, exp_g.req,
                   out_request_index);
        end
        case (exp_g.status)
          wfba_pkg::ST_LOADED:    n_loaded++;
          wfba_pkg::ST_ALLOCATED: n_granted++;
          wfba_pkg::ST_NO_FIT:    n_no_fit++;
          default:                n_full++;
        endcase
      end
    end
  end

  // random result side back-pressure while idling is allowed
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_item(input wfba_pkg::opcode_t op, input logic [SZW-1:0] sz);
    int gap;
    gap = (allow_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_size_value <= sz;
    if (op == wfba_pkg::OP_LOAD && sent_sizes.size() < MAX_PART) sent_sizes.push_back(sz);
    if (op == wfba_pkg::OP_ALLOC) n_alloc++;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [SZW-1:0] pick_load_size();
    logic [SZW-1:0] corner [8];
    int r;
    corner = '{16'h0000, 16'h0001, 16'h00FF, 16'h0100, 16'h7FFF, 16'h8000, 16'hFFFE,
               16'hFFFF};
    r = $urandom_range(0, 9);
    if (r < 3) return corner[$urandom_range(0, 7)];
    if (r < 6) return SZW'($urandom_range(0, 63));
    return SZW'($urandom_range(0, 65535));
  endfunction

  // requests aim at loaded sizes so the fit boundary is hit often
  function automatic logic [SZW-1:0] pick_request_size();
    logic [SZW-1:0] s;
    int r;
    r = $urandom_range(0, 9);
    if (sent_sizes.size() == 0 || r < 2) return SZW'($urandom_range(0, 65535));
    if (r < 3) return '0;
    s = sent_sizes[$urandom_range(0, sent_sizes.size() - 1)];
    if (r < 8) return s;
    return s + 1'b1;
  endfunction

  // empty table, zero-size fits, ties, largest pick and wide bit patterns
  task automatic test_directed_cases();
    send_item(wfba_pkg::OP_ALLOC, 16'd5);
    send_item(wfba_pkg::OP_LOAD,  16'd0);
    send_item(wfba_pkg::OP_ALLOC, 16'd0);
    send_item(wfba_pkg::OP_ALLOC, 16'd0);
    send_item(wfba_pkg::OP_LOAD,  16'hFFFF);
    send_item(wfba_pkg::OP_LOAD,  16'd300);
    send_item(wfba_pkg::OP_LOAD,  16'd300);
    send_item(wfba_pkg::OP_LOAD,  16'd0);
    send_item(wfba_pkg::OP_ALLOC, 16'hFFFF);
    send_item(wfba_pkg::OP_ALLOC, 16'hFFFF);
    send_item(wfba_pkg::OP_ALLOC, 16'd200);
    send_item(wfba_pkg::OP_ALLOC, 16'd1);
    send_item(wfba_pkg::OP_ALLOC, 16'd0);
    send_item(wfba_pkg::OP_ALLOC, 16'd0);
    send_item(wfba_pkg::OP_LOAD,  16'h8000);
    send_item(wfba_pkg::OP_LOAD,  16'h7FFF);
    send_item(wfba_pkg::OP_LOAD,  16'hAAAA);
    send_item(wfba_pkg::OP_LOAD,  16'h5555);
    send_item(wfba_pkg::OP_ALLOC, 16'h5556);
    send_item(wfba_pkg::OP_ALLOC, 16'h8000);
    send_item(wfba_pkg::OP_ALLOC, 16'h7FFF);
  endtask

  // mixed loads and requests until the table is full
  task automatic test_random_fill();
    while (sent_sizes.size() < MAX_PART) begin
      if ($urandom_range(0, 9) < 4) send_item(wfba_pkg::OP_LOAD, pick_load_size());
      else send_item(wfba_pkg::OP_ALLOC, pick_request_size());
    end
  endtask

  // loads past the last slot, mixed with requests
  task automatic test_table_full();
    repeat (300) begin
      if ($urandom_range(0, 9) < 4) send_item(wfba_pkg::OP_LOAD, pick_load_size());
      else send_item(wfba_pkg::OP_ALLOC, pick_request_size());
    end
  endtask

  // long request stream so the request number wraps several times
  task automatic test_request_wrap(input int n_items);
    repeat (n_items) begin
      if ($urandom_range(0, 9) == 0) send_item(wfba_pkg::OP_LOAD, pick_load_size());
      else send_item(wfba_pkg::OP_ALLOC, pick_request_size());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_fill();
    test_table_full();
    test_request_wrap(750);
    // back-to-back tail with no idling on either side
    allow_idle = 1'b0;
    test_request_wrap(250);
    in_valid <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // every predicted result must have come out
    if (grant_queue.size() != 0) begin
      err_cnt++;
      $display("%0t: results missing expected %0d actual %0d", $time,
               grant_queue.size(), 0);
    end
    $display("covered %0d loads, %0d grants, %0d no-fit answers, %0d table-full answers",
             n_loaded, n_granted, n_no_fit, n_full);
    $display("%0d requests issued, request number wrapped %0d times, %0d mismatches",
             n_alloc, n_alloc / 256, err_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
